@@ rtl/wcme_pkg.sv @@
// ----------------------------------------------------------------------------
// Weight clip match error: shared types and constants
// Field widths, register indexes, request codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package wcme_pkg;

  localparam int WEIGHT_W         = 16;
  localparam int IDX_W            = 12;
  localparam int SUM_W            = 32;
  localparam int CNT_W            = 11;
  localparam int CFG_IDX_W        = 2;
  localparam int WEIGHT_FRAC_BITS = 8;

  localparam logic [WEIGHT_W-1:0] DARK_RESET  =
    WEIGHT_W'((255 << WEIGHT_FRAC_BITS) / 10);
  localparam logic [WEIGHT_W-1:0] LIMIT_RESET =
    WEIGHT_W'(10 << WEIGHT_FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_ERROR_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_FRAME_COUNT  = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  typedef struct packed {
    logic [SUM_W-1:0] kept_sum_diff;
    logic [SUM_W-1:0] kept_sum_change;
    logic [CNT_W-1:0] kept_count;
  } window_sum_t;

endpackage

`default_nettype wire

@@ rtl/wcme_ref_mem.sv @@
// ----------------------------------------------------------------------------
// Reference weight memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wcme_ref_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [AW-1:0]                    waddr,
  input  wire logic [wcme_pkg::WEIGHT_W-1:0]    wdata,
  input  wire logic                             re,
  input  wire logic [AW-1:0]                    raddr,
  output logic      [wcme_pkg::WEIGHT_W-1:0]    rdata
);
  import wcme_pkg::*;

  logic [WEIGHT_W-1:0] mem_r [DEPTH];
  logic [WEIGHT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/wcme_window.sv @@
// ----------------------------------------------------------------------------
// Window accumulator
// Issues reference reads and loads, then trims, accumulates and snapshots.
// ----------------------------------------------------------------------------
`default_nettype none

module wcme_window #(
  parameter int REF_DEPTH = 1024,
  parameter int AW        = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             acc,
  input  wire logic                             req_type,
  input  wire logic [wcme_pkg::WEIGHT_W-1:0]    weight,
  input  wire logic [wcme_pkg::IDX_W-1:0]       ref_index,
  input  wire logic                             last,
  input  wire logic [wcme_pkg::WEIGHT_W-1:0]    dark_threshold,
  input  wire logic [wcme_pkg::CNT_W-1:0]       ref_frame_count,
  output logic                                  mem_we,
  output logic      [AW-1:0]                    mem_waddr,
  output logic      [wcme_pkg::WEIGHT_W-1:0]    mem_wdata,
  output logic                                  mem_re,
  output logic      [AW-1:0]                    mem_raddr,
  input  wire logic [wcme_pkg::WEIGHT_W-1:0]    mem_rdata,
  output logic                                  last_pending,
  output logic                                  div_start,
  output wcme_pkg::window_sum_t                 div_sums
);
  import wcme_pkg::*;

  logic                 s1_v_r, s1_last_r;
  logic [WEIGHT_W-1:0]  s1_w_r;
  logic [IDX_W-1:0]     s1_idx_r;

  logic                 trimming_r, trimming_nxt;
  logic                 stopped_r, stopped_nxt;
  logic [SUM_W-1:0]     sum_diff_r, sum_diff_nxt;
  logic [SUM_W-1:0]     sum_chg_r, sum_chg_nxt;
  logic [SUM_W-1:0]     kept_diff_r, kept_diff_nxt;
  logic [SUM_W-1:0]     kept_chg_r, kept_chg_nxt;
  logic [16:0]          prev_diff_r, prev_diff_nxt;
  logic [CNT_W-1:0]     counted_r, counted_nxt;
  logic [CNT_W-1:0]     kept_cnt_r, kept_cnt_nxt;

  logic                 load_ok;
  logic                 trim_now, count_en, in_range;
  logic [CNT_W-1:0]     k;
  logic [16:0]          d, abs_d;
  logic [17:0]          ch, abs_ch;
  logic [SUM_W:0]       add_d, add_ch;

  // request side: memory access in the accept cycle
  assign load_ok   = ~ref_index[IDX_W-1] &&
                     ({21'd0, ref_index[CNT_W-1:0]} < 32'(REF_DEPTH));
  assign mem_we    = acc && (req_type == REQ_LOAD) && load_ok;
  assign mem_waddr = AW'(ref_index[CNT_W-1:0]);
  assign mem_wdata = weight;
  assign mem_re    = acc && (req_type == REQ_FRAME);
  assign mem_raddr = AW'(ref_index[CNT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
    end else begin
      s1_v_r    <= mem_re;
      s1_last_r <= mem_re && last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      s1_w_r   <= weight;
      s1_idx_r <= ref_index;
    end
  end

  assign k        = s1_idx_r[CNT_W-1:0];
  assign trim_now = trimming_r && !(s1_w_r >= dark_threshold);
  assign in_range = (k < ref_frame_count) && ({21'd0, k} < 32'(REF_DEPTH));
  assign count_en = s1_v_r && !trim_now && !stopped_r && !s1_idx_r[IDX_W-1];

  assign d      = {1'b0, s1_w_r} - {1'b0, mem_rdata};
  assign ch     = {d[16], d} - {prev_diff_r[16], prev_diff_r};
  assign abs_d  = d[16] ? (~d + 17'd1) : d;
  assign abs_ch = ch[17] ? (~ch + 18'd1) : ch;
  assign add_d  = {1'b0, sum_diff_r} + 33'(abs_d);
  assign add_ch = {1'b0, sum_chg_r} + 33'(abs_ch);

  always_comb begin
    trimming_nxt  = trimming_r;
    stopped_nxt   = stopped_r;
    sum_diff_nxt  = sum_diff_r;
    sum_chg_nxt   = sum_chg_r;
    kept_diff_nxt = kept_diff_r;
    kept_chg_nxt  = kept_chg_r;
    prev_diff_nxt = prev_diff_r;
    counted_nxt   = counted_r;
    kept_cnt_nxt  = kept_cnt_r;

    if (s1_v_r) begin
      trimming_nxt = trim_now;
    end
    if (count_en) begin
      if (!in_range) begin
        stopped_nxt = 1'b1;
      end else begin
        sum_diff_nxt  = add_d[SUM_W]  ? {SUM_W{1'b1}} : add_d[SUM_W-1:0];
        sum_chg_nxt   = add_ch[SUM_W] ? {SUM_W{1'b1}} : add_ch[SUM_W-1:0];
        prev_diff_nxt = d;
        if (s1_w_r > dark_threshold) begin
          kept_diff_nxt = sum_diff_nxt;
          kept_chg_nxt  = sum_chg_nxt;
          kept_cnt_nxt  = counted_r;
        end
        if (counted_r != {CNT_W{1'b1}}) begin
          counted_nxt = counted_r + 1'b1;
        end
      end
    end

    div_sums.kept_sum_diff   = kept_diff_nxt;
    div_sums.kept_sum_change = kept_chg_nxt;
    div_sums.kept_count      = kept_cnt_nxt;

    // window closes: back to the post-reset state
    if (s1_last_r) begin
      trimming_nxt  = 1'b1;
      stopped_nxt   = 1'b0;
      sum_diff_nxt  = '0;
      sum_chg_nxt   = '0;
      kept_diff_nxt = '0;
      kept_chg_nxt  = '0;
      prev_diff_nxt = '0;
      counted_nxt   = '0;
      kept_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trimming_r  <= 1'b1;
      stopped_r   <= 1'b0;
      sum_diff_r  <= '0;
      sum_chg_r   <= '0;
      kept_diff_r <= '0;
      kept_chg_r  <= '0;
      prev_diff_r <= '0;
      counted_r   <= '0;
      kept_cnt_r  <= '0;
    end else begin
      trimming_r  <= trimming_nxt;
      stopped_r   <= stopped_nxt;
      sum_diff_r  <= sum_diff_nxt;
      sum_chg_r   <= sum_chg_nxt;
      kept_diff_r <= kept_diff_nxt;
      kept_chg_r  <= kept_chg_nxt;
      prev_diff_r <= prev_diff_nxt;
      counted_r   <= counted_nxt;
      kept_cnt_r  <= kept_cnt_nxt;
    end
  end

  assign last_pending = s1_last_r;
  assign div_start    = s1_last_r;

endmodule

`default_nettype wire

@@ rtl/wcme_div.sv @@
// ----------------------------------------------------------------------------
// Mean error divider
// Picks the numerator, then restoring division one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wcme_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire wcme_pkg::window_sum_t            sums,
  input  wire logic [wcme_pkg::WEIGHT_W-1:0]    limit,
  output logic                                  busy,
  output logic                                  res_valid,
  input  wire logic                             res_take,
  output logic      [wcme_pkg::WEIGHT_W-1:0]    match_error,
  output logic                                  no_match
);
  import wcme_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } div_state_t;

  div_state_t           state_r, state_nxt;
  logic [SUM_W-1:0]     diff_r, chg_r, num_r;
  logic [CNT_W-1:0]     cnt_r, rem_r;
  logic [WEIGHT_W-1:0]  lim_r;
  logic [4:0]           step_r;
  logic                 nm_r;

  logic [26:0]          prod;
  logic                 use_chg;
  logic [CNT_W:0]       shifted, trial;
  logic                 fits;

  assign prod    = lim_r * cnt_r;
  assign use_chg = (chg_r < diff_r) && ({5'd0, prod} > diff_r);
  assign shifted = {rem_r, num_r[SUM_W-1]};
  assign trial   = shifted - {1'b0, cnt_r};
  assign fits    = shifted >= {1'b0, cnt_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (sums.kept_count == '0) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_RUN;
      ST_RUN: begin
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        diff_r <= sums.kept_sum_diff;
        chg_r  <= sums.kept_sum_change;
        cnt_r  <= sums.kept_count;
        lim_r  <= limit;
        num_r  <= '0;
        nm_r   <= (sums.kept_count == '0);
      end
      ST_PREP: begin
        num_r  <= use_chg ? chg_r : diff_r;
        rem_r  <= '0;
        step_r <= 5'(SUM_W - 1);
      end
      ST_RUN: begin
        rem_r  <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        num_r  <= {num_r[SUM_W-2:0], fits};
        step_r <= step_r - 5'd1;
      end
      default: begin
      end
    endcase
  end

  assign busy        = (state_r != ST_IDLE);
  assign res_valid   = (state_r == ST_DONE);
  assign no_match    = nm_r;
  assign match_error = (|num_r[SUM_W-1:WEIGHT_W]) ? {WEIGHT_W{1'b1}}
                                                  : num_r[WEIGHT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/weight_clip_match_error.sv @@
// ----------------------------------------------------------------------------
// Weight clip match error
// The last frame request is registered in the window stage, then the divider
// picks the numerator and divides bit by bit; an empty window skips to done.
// Throughput: one request per cycle while in_stall is low; a last frame holds
// off requests until the output register, which waits out a stall, takes its result.
// Reset: synchronous active-low; window state and registers take their reset
// values, the reference memory keeps no reset and is valid only once loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module weight_clip_match_error #(
  parameter int REF_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_req_type,
  input  wire logic [wcme_pkg::WEIGHT_W-1:0]     in_weight,
  input  wire logic [wcme_pkg::IDX_W-1:0]        in_ref_index,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [wcme_pkg::WEIGHT_W-1:0]     out_match_error,
  output logic                                   out_no_match,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wcme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wcme_pkg::WEIGHT_W-1:0]     cfg_data
);
  import wcme_pkg::*;

  localparam int AW = $clog2(REF_DEPTH);

  logic [WEIGHT_W-1:0]  dark_r, limit_r;
  logic [CNT_W-1:0]     ref_cnt_r;

  logic                 in_acc;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WEIGHT_W-1:0]  mem_wdata, mem_rdata;
  logic                 last_pending, div_start, div_busy;
  window_sum_t          div_sums;
  logic                 res_valid, res_take, res_no_match;
  logic [WEIGHT_W-1:0]  res_error;

  logic                 out_valid_r;
  logic [WEIGHT_W-1:0]  out_error_r;
  logic                 out_nm_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r    <= DARK_RESET;
      limit_r   <= LIMIT_RESET;
      ref_cnt_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DARK_THRESHOLD:   dark_r    <= cfg_data;
        CFG_MEAN_ERROR_LIMIT: limit_r   <= cfg_data;
        CFG_REF_FRAME_COUNT:  ref_cnt_r <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = last_pending || div_busy;
  assign in_acc   = in_valid && !in_stall;

  wcme_window #(
    .REF_DEPTH (REF_DEPTH),
    .AW        (AW)
  ) u_window (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (in_acc),
    .req_type        (in_req_type),
    .weight          (in_weight),
    .ref_index       (in_ref_index),
    .last            (in_last),
    .dark_threshold  (dark_r),
    .ref_frame_count (ref_cnt_r),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .last_pending    (last_pending),
    .div_start       (div_start),
    .div_sums        (div_sums)
  );

  wcme_ref_mem #(
    .DEPTH (REF_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wcme_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .sums        (div_sums),
    .limit       (limit_r),
    .busy        (div_busy),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .match_error (res_error),
    .no_match    (res_no_match)
  );

  // output register takes a result when empty or draining, freeing the divider
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_error_r <= res_no_match ? '0 : res_error;
      out_nm_r    <= res_no_match;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_error = out_error_r;
  assign out_no_match    = out_nm_r;

endmodule

`default_nettype wire

@@ rtl/wcme_checker.sv @@
// ----------------------------------------------------------------------------
// Weight clip match error port checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wcme_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              in_req_type,
  input wire logic                              in_last,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [wcme_pkg::WEIGHT_W-1:0]     out_match_error,
  input wire logic                              out_no_match
);
  import wcme_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && out_stall) |-> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && out_stall)
      |-> $stable(out_match_error) && $stable(out_no_match))
    else $error("result payload changed while stalled");

  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_match |-> out_match_error == '0)
    else $error("no_match result carries a non-zero error");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_FRAME) && in_last |=> in_stall)
    else $error("request taken straight after a window end");

endmodule

bind weight_clip_match_error wcme_checker u_wcme_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight clip match error: self-checking bench
// Feeds reference loads and observed frame windows into the block and
// compares each window's error, result by result, against a bit-accurate
// predictor held in a scoreboard class. Both channels idle and stall at
// random, with a quiet stretch, one long output hold-off and drains between
// register settings.
// ----------------------------------------------------------------------------
module tb;
  import wcme_pkg::*;

  localparam int REF_DEPTH      = 1024;
  localparam int REF_AW         = $clog2(REF_DEPTH);
  localparam int COUNT_MAX      = (1 << CNT_W) - 1;
  localparam int N_ITEMS        = 1850;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_FRAMES    = 120;

  typedef struct packed {
    logic [WEIGHT_W-1:0] match_error;
    logic                no_match;
  } match_result_t;

  class window_error_book;
    logic [WEIGHT_W-1:0] ref_mem [REF_DEPTH];
    logic [WEIGHT_W-1:0] dark_thr, err_limit;
    logic [CNT_W-1:0]    ref_count;
    bit                  trimming, stopped;
    logic [SUM_W-1:0]    diff_sum, change_sum, kept_diff, kept_change;
    int                  prev_diff;
    logic [CNT_W-1:0]    counted, kept_count;
    match_result_t       expected_errors [$];
    int                  mismatches, results_seen, empty_windows;

    function new();
      foreach (ref_mem[i]) ref_mem[i] = '0;
      dark_thr      = DARK_RESET;
      err_limit     = LIMIT_RESET;
      ref_count     = '0;
      mismatches    = 0;
      results_seen  = 0;
      empty_windows = 0;
      clear_window();
    endfunction

    function void clear_window();
      trimming    = 1'b1;
      stopped     = 1'b0;
      diff_sum    = '0;
      change_sum  = '0;
      kept_diff   = '0;
      kept_change = '0;
      prev_diff   = 0;
      counted     = '0;
      kept_count  = '0;
    endfunction

    function logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a, input int b);
      longint s;
      s = a;
      s = s + b;
      return (s > 64'h0000_0000_FFFF_FFFF) ? '1 : s[SUM_W-1:0];
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [WEIGHT_W-1:0] data);
      case (idx)
        CFG_DARK_THRESHOLD:   dark_thr  = data;
        CFG_MEAN_ERROR_LIMIT: err_limit = data;
        CFG_REF_FRAME_COUNT:  ref_count = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_request(input logic req_type, input logic [WEIGHT_W-1:0] w,
                               input logic [IDX_W-1:0] idx, input logic last);
      int            d, ch, lim;
      longint        num, dsum, bound, q;
      match_result_t r;
      if (req_type == REQ_LOAD) begin
        if (!idx[IDX_W-1] && idx < REF_DEPTH) ref_mem[idx[REF_AW-1:0]] = w;
        return;
      end
      if (trimming && w >= dark_thr) trimming = 1'b0;
      if (!trimming && !stopped && !idx[IDX_W-1]) begin
        lim = (ref_count > REF_DEPTH) ? REF_DEPTH : int'(ref_count);
        if (idx >= lim) begin
          stopped = 1'b1;
        end else begin
          d  = int'(w) - int'(ref_mem[idx[REF_AW-1:0]]);
          ch = d - prev_diff;
          diff_sum   = sat_add(diff_sum, (d < 0) ? -d : d);
          change_sum = sat_add(change_sum, (ch < 0) ? -ch : ch);
          prev_diff  = d;
          if (w > dark_thr) begin
            kept_diff   = diff_sum;
            kept_change = change_sum;
            kept_count  = counted;
          end
          if (counted < COUNT_MAX) counted = counted + 1'b1;
        end
      end
      if (!last) return;
      if (kept_count == 0) begin
        r.match_error = '0;
        r.no_match    = 1'b1;
        empty_windows++;
      end else begin
        dsum  = kept_diff;
        bound = err_limit;
        bound = bound * kept_count;
        num   = dsum;
        if (kept_change < kept_diff && dsum < bound) num = kept_change;
        q = num / kept_count;
        r.match_error = (q > 65535) ? 16'hFFFF : q[WEIGHT_W-1:0];
        r.no_match    = 1'b0;
      end
      expected_errors.push_back(r);
      clear_window();
    endfunction

    function void check_result(input logic [WEIGHT_W-1:0] err, input logic nm);
      match_result_t want;
      results_seen++;
      if (expected_errors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no window pending: error %h no_match %b",
                   $realtime, err, nm);
        return;
      end
      want = expected_errors.pop_front();
      if (want.match_error !== err || want.no_match !== nm) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected error %h no_match %b, got error %h no_match %b",
                   $realtime, want.match_error, want.no_match, err, nm);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  in_req_type     = 1'b0;
  logic [WEIGHT_W-1:0]   in_weight       = '0;
  logic [IDX_W-1:0]      in_ref_index    = '0;
  logic                  in_last         = 1'b0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [WEIGHT_W-1:0]   out_match_error;
  logic                  out_no_match;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [WEIGHT_W-1:0]   cfg_data        = '0;

  window_error_book book;
  bit loaded [REF_DEPTH];
  bit calm       = 1'b0;
  int hold_asked = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int idle_cycles = 0;
  int n_items = 0, n_loads = 0, n_frames = 0, n_cfg = 0;

  weight_clip_match_error #(.REF_DEPTH(REF_DEPTH)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_weight       (in_weight),
    .in_ref_index    (in_ref_index),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_error (out_match_error),
    .out_no_match    (out_no_match),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stall, quiet stretch, and the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 36);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_match_error, out_no_match);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_req(input logic req_type, input logic [WEIGHT_W-1:0] w,
                          input logic [IDX_W-1:0] idx, input logic last);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req_type;
    in_weight    <= w;
    in_ref_index <= idx;
    in_last      <= last;
    do @(posedge clk); while (in_stall);
    book.take_request(req_type, w, idx, last);
    n_items++;
    if (req_type == REQ_LOAD) n_loads++;
    else n_frames++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    book.set_register(idx, data);
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every pending window result, then let trailing requests clear
  task automatic settle();
    in_valid <= 1'b0;
    while (book.expected_errors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index(input int hint, input bit noisy);
    int lim, k, r;
    lim = (book.ref_count > REF_DEPTH) ? REF_DEPTH : int'(book.ref_count);
    r = $urandom_range(99);
    if (r < (noisy ? 20 : 4)) return IDX_W'(-int'($urandom_range(1, 2048)));
    if (r < (noisy ? 40 : 7) || lim == 0) return IDX_W'($urandom_range(lim, 2047));
    if (hint >= 0 && hint < lim && loaded[hint]) return IDX_W'(hint);
    repeat (16) begin
      k = $urandom_range(0, lim - 1);
      if (loaded[k]) return IDX_W'(k);
    end
    return IDX_W'($urandom_range(lim, 2047));
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(input logic [IDX_W-1:0] idx);
    int base, w, r;
    base = (!idx[IDX_W-1] && idx < REF_DEPTH) ? int'(book.ref_mem[idx[REF_AW-1:0]])
                                               : int'($urandom_range(0, 65535));
    r = $urandom_range(99);
    if (r < 45)      w = base + int'($urandom_range(0, 4096)) - 2048;
    else if (r < 65) w = base + int'($urandom_range(0, 32768)) - 16384;
    else if (r < 80) w = $urandom_range(0, 65535);
    else if (r < 92) w = int'(book.dark_thr) + int'($urandom_range(0, 2)) - 1;
    else             w = $urandom_range(1) ? 65535 : 0;
    if (w < 0) w = 0;
    if (w > 65535) w = 65535;
    return w[WEIGHT_W-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_reg16();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 16'h0000;
    if (r < 24) return 16'hFFFF;
    if (r < 70) return WEIGHT_W'($urandom_range(0, 16'h3000));
    return WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_load();
    int a, r;
    r = $urandom_range(99);
    if (r < 50)      a = $urandom_range(0, 127);
    else if (r < 90) a = $urandom_range(0, REF_DEPTH - 1);
    else if (r < 95) a = -int'($urandom_range(1, 2048));
    else             a = $urandom_range(REF_DEPTH, 2047);
    if (a >= 0 && a < REF_DEPTH) loaded[a] = 1'b1;
    send_req(REQ_LOAD, WEIGHT_W'($urandom_range(0, 65535)), IDX_W'(a),
             1'($urandom_range(1)));
  endtask

  task automatic run_window();
    int               len, hint;
    bit               tidy;
    logic [IDX_W-1:0] idx;
    tidy = ($urandom_range(99) < 85);
    len  = ($urandom_range(99) < 90) ? $urandom_range(1, 16) : $urandom_range(17, 80);
    if (tidy) begin
      repeat ($urandom_range(0, 3))
        send_req(REQ_FRAME, (book.dark_thr == 0) ? 16'h0000
                 : WEIGHT_W'($urandom_range(0, book.dark_thr - 1)),
                 pick_index(-1, 1'b0), 1'b0);
    end
    hint = -1;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < (tidy ? 6 : 25)) send_load();
      if (tidy) begin
        idx = pick_index(hint, 1'b0);
        if (!idx[IDX_W-1]) hint = int'(idx) + 1;
        send_req(REQ_FRAME, pick_weight(idx), idx, i == len - 1);
      end else begin
        idx = pick_index(-1, 1'b1);
        send_req(REQ_FRAME, WEIGHT_W'($urandom_range(0, 65535)), idx,
                 (i == len - 1) || ($urandom_range(99) < 10));
      end
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    book = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no reference frames yet, so the first index stops the window
    send_req(REQ_FRAME, 16'hFFFF, 12'd0, 1'b1);
    send_req(REQ_LOAD, 16'h0000, 12'd0, 1'b0);
    send_req(REQ_LOAD, 16'hFFFF, 12'd1, 1'b1);
    send_req(REQ_LOAD, DARK_RESET, 12'd2, 1'b0);
    send_req(REQ_LOAD, 16'h4000, 12'd3, 1'b0);
    // out-of-range load addresses are dropped
    send_req(REQ_LOAD, 16'h1234, 12'hFFF, 1'b0);
    send_req(REQ_LOAD, 16'hBEEF, 12'd1024, 1'b0);
    send_req(REQ_LOAD, 16'h5A5A, 12'h800, 1'b0);
    send_req(REQ_LOAD, 16'hA5A5, 12'h7FF, 1'b1);
    for (int i = 0; i < 4; i++) loaded[i] = 1'b1;
    settle();
    write_reg(CFG_REF_FRAME_COUNT, 16'd4);

    send_req(REQ_FRAME, 16'h0100, 12'd0, 1'b0);
    send_req(REQ_FRAME, DARK_RESET, 12'd0, 1'b0);
    send_req(REQ_FRAME, 16'hFFFF, 12'd1, 1'b0);
    send_req(REQ_FRAME, 16'h8000, 12'hFFB, 1'b0);
    send_req(REQ_FRAME, 16'h3000, 12'd3, 1'b0);
    send_req(REQ_FRAME, 16'hFFFF, 12'd4, 1'b0);
    send_req(REQ_FRAME, 16'h5000, 12'd2, 1'b0);
    send_req(REQ_FRAME, 16'h0000, 12'd0, 1'b1);
    // still trimming at the end
    send_req(REQ_FRAME, 16'h0000, 12'd0, 1'b0);
    send_req(REQ_FRAME, 16'h1000, 12'd1, 1'b1);
    send_req(REQ_FRAME, 16'h8000, 12'd2, 1'b1);
    send_req(REQ_FRAME, 16'h2000, 12'd0, 1'b0);
    send_req(REQ_FRAME, 16'h2100, 12'd0, 1'b0);
    send_req(REQ_FRAME, 16'h2200, 12'd3, 1'b0);
    send_req(REQ_FRAME, 16'hFFFF, 12'h800, 1'b1);

    settle();
    for (int a = 0; a < 128; a++) begin
      loaded[a] = 1'b1;
      send_req(REQ_LOAD, WEIGHT_W'($urandom_range(0, 65535)), IDX_W'(a), 1'b0);
    end
    settle();
    write_reg(CFG_DARK_THRESHOLD, 16'hFFFF);
    write_reg(CFG_MEAN_ERROR_LIMIT, 16'h0000);
    write_reg(CFG_REF_FRAME_COUNT, 16'd128);
    repeat (3) run_window();

    while (n_items < N_ITEMS - LONG_FRAMES) begin
      settle();
      if ($urandom_range(99) < 60) write_reg(CFG_DARK_THRESHOLD, pick_reg16());
      if ($urandom_range(99) < 60) write_reg(CFG_MEAN_ERROR_LIMIT, pick_reg16());
      if ($urandom_range(99) < 60) begin
        case ($urandom_range(9))
          0:       write_reg(CFG_REF_FRAME_COUNT, 16'd0);
          1:       write_reg(CFG_REF_FRAME_COUNT, WEIGHT_W'(REF_DEPTH));
          2, 3:    write_reg(CFG_REF_FRAME_COUNT, WEIGHT_W'($urandom_range(0, REF_DEPTH)));
          default: write_reg(CFG_REF_FRAME_COUNT, WEIGHT_W'($urandom_range(1, 128)));
        endcase
      end
      if (n_items > 400 && !held) begin
        held = 1'b1;
        hold_asked++;
      end
      calm = (n_items >= 700 && n_items < 1000);
      repeat ($urandom_range(1, 5)) run_window();
    end
    calm = 1'b0;

    // one long window at a fixed index
    settle();
    write_reg(CFG_DARK_THRESHOLD, 16'h0000);
    write_reg(CFG_MEAN_ERROR_LIMIT, 16'hFFFF);
    write_reg(CFG_REF_FRAME_COUNT, WEIGHT_W'(REF_DEPTH));
    for (int i = 0; i < LONG_FRAMES; i++)
      send_req(REQ_FRAME, i[0] ? 16'hFFFF : 16'h0000, 12'd0, i == LONG_FRAMES - 1);
    settle();

    $display("Covered %0d requests: %0d reference loads, %0d frames, %0d register writes.",
             n_items, n_loads, n_frames, n_cfg);
    $display("Checked %0d window results, %0d of them without a match, %0d mismatches.",
             book.results_seen, book.empty_windows, book.mismatches);
    if (book.mismatches == 0 && book.expected_errors.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
